// ===== rtl/srx_pkg.sv =====
// Shared types and constants for the serial frame receiver.
// Used by srx_ctrl, srx_datapath and serial_frame_receiver; no dependencies.

package srx_pkg;

    // Default frame buffer depth.
    localparam int BufferSizeDefault = 32;

    // Widths of the configuration port.
    localparam int CfgAddrWidth = 3;
    localparam int CfgDataWidth = 16;

    // Widths of the stream payloads.
    localparam int InDataWidth  = 8;
    localparam int OutDataWidth = 16;
    localparam int KindWidth    = 2;
    localparam int IndexWidth   = 6;
    localparam int IdleWidth    = 17;

    // Configuration register indexes.
    localparam logic [CfgAddrWidth-1:0] RegTimeoutTicks = 3'd0;
    localparam logic [CfgAddrWidth-1:0] RegRequestCode  = 3'd1;
    localparam logic [CfgAddrWidth-1:0] RegAckCode      = 3'd2;
    localparam logic [CfgAddrWidth-1:0] RegStartCode    = 3'd3;
    localparam logic [CfgAddrWidth-1:0] RegResyncLimit  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] TimeoutTicksReset = 16'd100;
    localparam logic [7:0]  RequestCodeReset  = 8'd5;
    localparam logic [7:0]  AckCodeReset      = 8'd6;
    localparam logic [7:0]  StartCodeReset    = 8'd2;
    localparam logic [3:0]  ResyncLimitReset  = 4'd10;

    // Input action codes.
    localparam logic ActionByte = 1'b0;
    localparam logic ActionTick = 1'b1;

    // Result kinds.
    localparam logic [KindWidth-1:0] KindFrameByte = 2'd0;
    localparam logic [KindWidth-1:0] KindTimeout   = 2'd1;
    localparam logic [KindWidth-1:0] KindLengthErr = 2'd2;
    localparam logic [KindWidth-1:0] KindResync    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;       // Process the accepted input beat.
        logic rd_issue;   // Read the frame buffer at the read pointer.
        logic load_mem;   // Load the read byte into the output register.
    } srx_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // Output register can take a result this cycle.
        logic res_frame;  // Current input completes a frame.
        logic res_single; // Current input gives a single result.
        logic rd_last;    // Read pointer is at the final frame byte.
    } srx_status_t;

endpackage

// ===== rtl/serial_frame_receiver.sv =====
// Top level of the serial frame receiver: joins controller and datapath.
// Depends on srx_pkg, srx_ctrl and srx_datapath.

// Deframes a stream of received bytes and time ticks. An input beat is taken
// whenever the output register is free and no frame is being drained; a byte
// or tick that gives at most one result is done as it is taken. A byte that completes a
// length-prefixed frame of N bytes holds off input while the frame is read
// back from the buffer: each byte is read on the single registered read port
// and then loaded into the output register, later if the sink stalls. The
// frame buffer needs no clearing after reset.

module serial_frame_receiver #(
    parameter int BUFFER_SIZE = srx_pkg::BufferSizeDefault
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [srx_pkg::CfgAddrWidth-1:0]  cfg_addr,
    input  logic [srx_pkg::CfgDataWidth-1:0]  cfg_wdata,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [srx_pkg::InDataWidth-1:0]   s_tdata,  // [7:0] rx_byte
    input  logic                              s_tuser,  // [0] action
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [srx_pkg::OutDataWidth-1:0]  m_tdata,  // [7:0] frame_byte, [13:8] byte_index
    output logic [srx_pkg::KindWidth-1:0]     m_tuser,  // [1:0] kind
    output logic                              m_tlast   // last
);

    srx_pkg::srx_cmd_t    cmd;
    srx_pkg::srx_status_t status;
    logic [7:0]                     out_byte;
    logic [srx_pkg::IndexWidth-1:0] out_index;

    // Controller.
    srx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    srx_datapath #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_action (s_tuser),
        .in_byte   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_kind  (m_tuser),
        .out_byte  (out_byte),
        .out_index (out_index),
        .out_last  (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    // Pack the result beat.
    assign m_tdata = {2'b00, out_index, out_byte};

    // A result is never loaded over one the sink has not taken.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_mem || (cmd.step && status.res_single)) |-> status.out_free)
        else $error("result loaded while output register busy");

    // No input beat is taken while a frame is being drained.
    a_no_input_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_issue || cmd.load_mem) |-> !s_tready)
        else $error("input ready during frame drain");

    // A completed frame starts draining on the next cycle.
    a_frame_drain_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && status.res_frame) |=> cmd.rd_issue)
        else $error("frame drain did not start");

    // Every buffer read is followed by a load attempt, so input stays blocked.
    a_read_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |=> !s_tready && !cmd.rd_issue)
        else $error("buffer read not followed by output load");

endmodule

// ===== rtl/srx_ctrl.sv =====
// Controller state machine of the serial frame receiver.
// Depends on srx_pkg for the command and status types.

module srx_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  srx_pkg::srx_status_t status,
    output srx_pkg::srx_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Inputs are taken only between frame drains and while the output slot is free.
    assign s_tready = (state_reg == S_IDLE) && status.out_free;

    // Next state and command decode.
    always_comb begin
        state_next   = state_reg;
        cmd.step     = 1'b0;
        cmd.rd_issue = 1'b0;
        cmd.load_mem = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.step = 1'b1;
                    if (status.res_frame) begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_LOAD;
            end
            S_LOAD: begin
                if (status.out_free) begin
                    cmd.load_mem = 1'b1;
                    state_next   = status.rd_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/srx_datapath.sv =====
// Datapath of the serial frame receiver: configuration registers, frame buffer,
// framing state and the output register. Depends on srx_pkg.

module srx_datapath #(
    parameter int BUFFER_SIZE = srx_pkg::BufferSizeDefault
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [srx_pkg::CfgAddrWidth-1:0]  cfg_addr,
    input  logic [srx_pkg::CfgDataWidth-1:0]  cfg_wdata,
    input  logic                              in_action,
    input  logic [7:0]                        in_byte,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [srx_pkg::KindWidth-1:0]     out_kind,
    output logic [7:0]                        out_byte,
    output logic [srx_pkg::IndexWidth-1:0]    out_index,
    output logic                              out_last,
    input  srx_pkg::srx_cmd_t                 cmd,
    output srx_pkg::srx_status_t              status
);

    localparam int IW = (BUFFER_SIZE > 1) ? $clog2(BUFFER_SIZE) : 1;
    localparam int PW = $clog2(BUFFER_SIZE + 1);
    localparam int DW = srx_pkg::IdleWidth;
    localparam logic [PW-1:0] BufLimit = PW'(BUFFER_SIZE);
    localparam logic [DW-1:0] IdleMax  = {DW{1'b1}};

    // Configuration registers.
    logic [15:0] timeout_reg;
    logic [7:0]  request_reg;
    logic [7:0]  ack_reg;
    logic [7:0]  start_reg;
    logic [3:0]  resync_reg;

    // Framing state.
    logic [PW-1:0] wp_reg,        wp_next;
    logic          receiving_reg, receiving_next;
    logic [DW-1:0] idle_reg,      idle_next;
    logic [3:0]    bad_reg,       bad_next;
    logic [7:0]    first_reg;
    logic [7:0]    len_reg;

    // Frame readout.
    logic [7:0]    frame_mem [BUFFER_SIZE];
    logic [7:0]    rd_data_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [PW-1:0] emit_len_reg;

    // Output register.
    logic                          m_valid_reg;
    logic [srx_pkg::KindWidth-1:0] m_kind_reg;
    logic [7:0]                    m_byte_reg;
    logic [srx_pkg::IndexWidth-1:0] m_index_reg;
    logic                          m_last_reg;

    // Step decode signals.
    logic [PW-1:0]                 wp_eff;
    logic [PW-1:0]                 wp_inc;
    logic [7:0]                    first_byte;
    logic [7:0]                    len_byte;
    logic [4:0]                    bad_inc;
    logic [DW-1:0]                 idle_inc;
    logic                          res_single;
    logic                          res_frame;
    logic [srx_pkg::KindWidth-1:0] res_kind;
    logic [7:0]                    res_byte;
    logic                          do_single;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= srx_pkg::TimeoutTicksReset;
            request_reg <= srx_pkg::RequestCodeReset;
            ack_reg     <= srx_pkg::AckCodeReset;
            start_reg   <= srx_pkg::StartCodeReset;
            resync_reg  <= srx_pkg::ResyncLimitReset;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                srx_pkg::RegTimeoutTicks: timeout_reg <= cfg_wdata;
                srx_pkg::RegRequestCode:  request_reg <= cfg_wdata[7:0];
                srx_pkg::RegAckCode:      ack_reg     <= cfg_wdata[7:0];
                srx_pkg::RegStartCode:    start_reg   <= cfg_wdata[7:0];
                srx_pkg::RegResyncLimit:  resync_reg  <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Write position after the wrap guard, and the frame header as seen by this byte.
    assign wp_eff     = (wp_reg >= BufLimit) ? '0 : wp_reg;
    assign wp_inc     = wp_eff + PW'(1);
    assign first_byte = (wp_eff == '0) ? in_byte : first_reg;
    assign len_byte   = (wp_eff == PW'(1)) ? in_byte : len_reg;
    assign bad_inc    = {1'b0, bad_reg} + 5'd1;
    assign idle_inc   = (idle_reg == IdleMax) ? idle_reg : idle_reg + DW'(1);

    // Framing decision for one input beat.
    always_comb begin
        wp_next        = wp_reg;
        receiving_next = receiving_reg;
        idle_next      = idle_reg;
        bad_next       = bad_reg;
        res_single     = 1'b0;
        res_frame      = 1'b0;
        res_kind       = srx_pkg::KindFrameByte;
        res_byte       = 8'd0;
        if (in_action == srx_pkg::ActionTick) begin
            // A tick only counts while a frame is open.
            if (receiving_reg) begin
                if (idle_inc > {1'b0, timeout_reg}) begin
                    wp_next        = '0;
                    receiving_next = 1'b0;
                    idle_next      = '0;
                    res_single     = 1'b1;
                    res_kind       = srx_pkg::KindTimeout;
                end else begin
                    idle_next = idle_inc;
                end
            end
        end else begin
            idle_next      = '0;
            wp_next        = '0;
            receiving_next = 1'b0;
            if (first_byte == request_reg || first_byte == ack_reg) begin
                // One-byte request or acknowledge frame.
                res_single = 1'b1;
                res_byte   = first_byte;
            end else if (first_byte != start_reg) begin
                // Bad first byte: count it, ask for resync past the limit.
                if (bad_inc > {1'b0, resync_reg}) begin
                    bad_next   = '0;
                    res_single = 1'b1;
                    res_kind   = srx_pkg::KindResync;
                end else begin
                    bad_next = bad_inc[3:0];
                end
            end else if (wp_inc <= PW'(1)) begin
                wp_next        = wp_inc;
                receiving_next = 1'b1;
            end else if (len_byte == 8'(wp_inc)) begin
                res_frame = 1'b1;
            end else if (wp_inc >= BufLimit) begin
                res_single = 1'b1;
                res_kind   = srx_pkg::KindLengthErr;
            end else begin
                wp_next        = wp_inc;
                receiving_next = 1'b1;
            end
        end
    end

    assign do_single = cmd.step && res_single;

    // Framing state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            receiving_reg <= 1'b0;
            idle_reg      <= '0;
            bad_reg       <= '0;
        end else if (cmd.step) begin
            wp_reg        <= wp_next;
            receiving_reg <= receiving_next;
            idle_reg      <= idle_next;
            bad_reg       <= bad_next;
        end
    end

    // Header copies of the first two stored bytes.
    always_ff @(posedge aclk) begin
        if (cmd.step && in_action == srx_pkg::ActionByte) begin
            if (wp_eff == '0) begin
                first_reg <= in_byte;
            end
            if (wp_eff == PW'(1)) begin
                len_reg <= in_byte;
            end
        end
    end

    // Frame buffer: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.step && in_action == srx_pkg::ActionByte) begin
            frame_mem[wp_eff[IW-1:0]] <= in_byte;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= frame_mem[rd_idx_reg];
        end
    end

    // Read pointer and length of the frame being drained.
    always_ff @(posedge aclk) begin
        if (cmd.step && res_frame) begin
            rd_idx_reg   <= '0;
            emit_len_reg <= wp_inc;
        end else if (cmd.load_mem) begin
            rd_idx_reg <= rd_idx_reg + IW'(1);
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_single || cmd.load_mem) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (do_single) begin
            m_kind_reg  <= res_kind;
            m_byte_reg  <= res_byte;
            m_index_reg <= '0;
            m_last_reg  <= 1'b1;
        end else if (cmd.load_mem) begin
            m_kind_reg  <= srx_pkg::KindFrameByte;
            m_byte_reg  <= rd_data_reg;
            m_index_reg <= srx_pkg::IndexWidth'(rd_idx_reg);
            m_last_reg  <= status.rd_last;
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign out_kind  = m_kind_reg;
    assign out_byte  = m_byte_reg;
    assign out_index = m_index_reg;
    assign out_last  = m_last_reg;

    // Status toward the controller.
    assign status.out_free   = !m_valid_reg || m_tready;
    assign status.res_frame  = res_frame;
    assign status.res_single = res_single;
    assign status.rd_last    = ({1'b0, rd_idx_reg} + (IW + 1)'(1)) == (IW + 1)'(emit_len_reg);

endmodule
